>>> rtl/mss_pkg.sv
// Shared types, symbol and event codes, and the control program of the melody symbol sequencer.
// Used by mss_useq, mss_dp and the top level; depends on nothing.
package mss_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;
    localparam logic [3:0] START_OCTAVE = 4'd4;
    localparam logic [3:0] OCTAVE_MAX = 4'd8;

    localparam int SYM_W = 5;
    localparam logic [SYM_W-1:0] SYM_NOTES = 5'd12;
    localparam logic [SYM_W-1:0] SYM_PAUSE = 5'd12;
    localparam logic [SYM_W-1:0] SYM_ODOWN = 5'd13;
    localparam logic [SYM_W-1:0] SYM_OUP = 5'd14;
    localparam logic [SYM_W-1:0] SYM_L1 = 5'd15;
    localparam logic [SYM_W-1:0] SYM_L2 = 5'd16;
    localparam logic [SYM_W-1:0] SYM_L4 = 5'd17;
    localparam logic [SYM_W-1:0] SYM_L8 = 5'd18;
    localparam logic [SYM_W-1:0] SYM_L16 = 5'd19;

    localparam logic [1:0] EV_HOLD = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_SILENCE = 2'd2;
    localparam logic [1:0] EV_END = 2'd3;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_FETCH = 4'd0;
    localparam logic [STEP_W-1:0] ST_DISPATCH = 4'd1;
    localparam logic [STEP_W-1:0] ST_CHK_IDLE = 4'd2;
    localparam logic [STEP_W-1:0] ST_CHK_HOLD = 4'd3;
    localparam logic [STEP_W-1:0] ST_HOLD_ONE = 4'd4;
    localparam logic [STEP_W-1:0] ST_WALK = 4'd5;
    localparam logic [STEP_W-1:0] ST_POP = 4'd6;
    localparam logic [STEP_W-1:0] ST_APPLY = 4'd7;
    localparam logic [STEP_W-1:0] ST_EMIT_SYM = 4'd8;
    localparam logic [STEP_W-1:0] ST_APPEND = 4'd9;
    localparam logic [STEP_W-1:0] ST_EMIT_IDLE = 4'd10;
    localparam logic [STEP_W-1:0] ST_HOLD_DEC = 4'd11;
    localparam logic [STEP_W-1:0] ST_EMIT_END = 4'd12;

    localparam logic [3:0] ACT_NONE = 4'd0;
    localparam logic [3:0] ACT_ACCEPT = 4'd1;
    localparam logic [3:0] ACT_APPEND = 4'd2;
    localparam logic [3:0] ACT_EMIT_IDLE = 4'd3;
    localparam logic [3:0] ACT_HOLD_DEC = 4'd4;
    localparam logic [3:0] ACT_HOLD_ONE = 4'd5;
    localparam logic [3:0] ACT_EMIT_END = 4'd6;
    localparam logic [3:0] ACT_POP = 4'd7;
    localparam logic [3:0] ACT_APPLY = 4'd8;
    localparam logic [3:0] ACT_EMIT_SYM = 4'd9;

    localparam logic [2:0] CND_NEVER = 3'd0;
    localparam logic [2:0] CND_ALWAYS = 3'd1;
    localparam logic [2:0] CND_APPEND = 3'd2;
    localparam logic [2:0] CND_IDLE = 3'd3;
    localparam logic [2:0] CND_HOLD = 3'd4;
    localparam logic [2:0] CND_EMPTY = 3'd5;
    localparam logic [2:0] CND_CTRL = 3'd6;

    typedef struct packed {
        logic              rdy;
        logic              ewait;
        logic [3:0]        act;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic       fire;
        logic [3:0] act;
    } ctrl_t;

    typedef struct packed {
        logic append;
        logic idle;
        logic hold_nz;
        logic empty;
        logic ctrl;
        logic out_free;
    } stat_t;

    function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            ST_FETCH:     w = '{1'b1, 1'b0, ACT_ACCEPT, CND_NEVER, ST_FETCH};
            ST_DISPATCH:  w = '{1'b0, 1'b0, ACT_NONE, CND_APPEND, ST_APPEND};
            ST_CHK_IDLE:  w = '{1'b0, 1'b0, ACT_NONE, CND_IDLE, ST_EMIT_IDLE};
            ST_CHK_HOLD:  w = '{1'b0, 1'b0, ACT_NONE, CND_HOLD, ST_HOLD_DEC};
            ST_HOLD_ONE:  w = '{1'b0, 1'b0, ACT_HOLD_ONE, CND_NEVER, ST_FETCH};
            ST_WALK:      w = '{1'b0, 1'b0, ACT_NONE, CND_EMPTY, ST_EMIT_END};
            ST_POP:       w = '{1'b0, 1'b0, ACT_POP, CND_NEVER, ST_FETCH};
            ST_APPLY:     w = '{1'b0, 1'b0, ACT_APPLY, CND_CTRL, ST_WALK};
            ST_EMIT_SYM:  w = '{1'b0, 1'b1, ACT_EMIT_SYM, CND_ALWAYS, ST_FETCH};
            ST_APPEND:    w = '{1'b0, 1'b0, ACT_APPEND, CND_ALWAYS, ST_FETCH};
            ST_EMIT_IDLE: w = '{1'b0, 1'b1, ACT_EMIT_IDLE, CND_ALWAYS, ST_FETCH};
            ST_HOLD_DEC:  w = '{1'b0, 1'b1, ACT_HOLD_DEC, CND_ALWAYS, ST_FETCH};
            ST_EMIT_END:  w = '{1'b0, 1'b1, ACT_EMIT_END, CND_ALWAYS, ST_FETCH};
            default:      w = '{1'b0, 1'b0, ACT_NONE, CND_ALWAYS, ST_FETCH};
        endcase
        return w;
    endfunction

    function automatic logic [3:0] hold_len(input logic [SYM_W-1:0] sym);
        logic [3:0] len;
        case (sym)
            SYM_L1:  len = 4'd15;
            SYM_L2:  len = 4'd7;
            SYM_L4:  len = 4'd3;
            SYM_L8:  len = 4'd1;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/mss_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module mss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mss_useq.sv
// Step counter and control program sequencer of the melody symbol sequencer.
// Depends on mss_pkg for the control word layout and the program table.
module mss_useq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  mss_pkg::stat_t stat,
    output logic          s_tready,
    output mss_pkg::ctrl_t ctrl
);

    logic [mss_pkg::STEP_W-1:0] step_reg;
    logic [mss_pkg::STEP_W-1:0] step_next;
    mss_pkg::ucode_t            cw;
    logic                       stall;
    logic                       taken;

    assign cw = mss_pkg::ucode(step_reg);
    assign stall = (cw.rdy && !s_tvalid) || (cw.ewait && !stat.out_free);

    always_comb begin
        unique case (cw.cond)
            mss_pkg::CND_NEVER:  taken = 1'b0;
            mss_pkg::CND_ALWAYS: taken = 1'b1;
            mss_pkg::CND_APPEND: taken = stat.append;
            mss_pkg::CND_IDLE:   taken = stat.idle;
            mss_pkg::CND_HOLD:   taken = stat.hold_nz;
            mss_pkg::CND_EMPTY:  taken = stat.empty;
            mss_pkg::CND_CTRL:   taken = stat.ctrl;
            default:             taken = 1'b1;
        endcase
        if (stall) begin
            step_next = step_reg;
        end else if (taken) begin
            step_next = cw.target;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= mss_pkg::ST_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

    assign s_tready = cw.rdy;
    assign ctrl.fire = !stall;
    assign ctrl.act = cw.act;

endmodule

>>> rtl/mss_dp.sv
// Datapath of the melody symbol sequencer: symbol queue, octave and hold counters, result register.
// Depends on mss_pkg and mss_ram; driven by the control words of mss_useq.
module mss_dp #(
    parameter int QUEUE_DEPTH = mss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mss_pkg::ctrl_t            ctrl,
    input  logic                      in_kind,
    input  logic [mss_pkg::SYM_W-1:0] in_symbol,
    input  logic                      in_first,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [1:0]                out_event,
    output logic [3:0]                out_note,
    output logic [3:0]                out_octave,
    output logic                      out_idle,
    output mss_pkg::stat_t            stat
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                      kind_reg;
    logic [mss_pkg::SYM_W-1:0] sym_in_reg;
    logic                      first_reg;
    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic                      idle_reg, idle_next;
    logic [3:0]                octave_reg, octave_next;
    logic [3:0]                hold_reg, hold_next;
    logic                      m_valid_reg, m_valid_next;
    logic [1:0]                ev_reg, ev_next;
    logic [3:0]                note_reg, note_next;
    logic [3:0]                oct_out_reg, oct_out_next;
    logic                      idle_out_reg, idle_out_next;

    logic [AW-1:0]             head_eff;
    logic [CW-1:0]             cnt_eff;
    logic [CW:0]               wr_sum;
    logic [CW:0]               wr_wrap;
    logic                      q_full;
    logic                      wr_en;
    logic                      rd_en;
    logic [mss_pkg::SYM_W-1:0] rsym;
    logic                      act_on;

    assign act_on = ctrl.fire;
    assign head_eff = first_reg ? '0 : head_reg;
    assign cnt_eff = first_reg ? '0 : count_reg;
    assign wr_sum = {1'b0, cnt_eff} + (CW+1)'(head_eff);
    assign wr_wrap = (wr_sum >= (CW+1)'(QUEUE_DEPTH)) ? wr_sum - (CW+1)'(QUEUE_DEPTH) : wr_sum;
    assign q_full = (cnt_eff == CW'(QUEUE_DEPTH));
    assign wr_en = act_on && (ctrl.act == mss_pkg::ACT_APPEND) && !q_full;
    assign rd_en = act_on && (ctrl.act == mss_pkg::ACT_POP);

    mss_ram #(
        .WIDTH(mss_pkg::SYM_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_wrap[AW-1:0]),
        .wr_data(sym_in_reg),
        .rd_en  (rd_en),
        .rd_addr(head_reg),
        .rd_data(rsym)
    );

    always_comb begin
        head_next = head_reg;
        count_next = count_reg;
        idle_next = idle_reg;
        octave_next = octave_reg;
        hold_next = hold_reg;
        ev_next = ev_reg;
        note_next = note_reg;
        oct_out_next = oct_out_reg;
        idle_out_next = idle_out_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (act_on) begin
            unique case (ctrl.act) inside
                mss_pkg::ACT_NONE, mss_pkg::ACT_ACCEPT: begin
                end
                mss_pkg::ACT_APPEND: begin
                    head_next = head_eff;
                    count_next = q_full ? cnt_eff : cnt_eff + 1'b1;
                    idle_next = 1'b0;
                end
                mss_pkg::ACT_EMIT_IDLE: begin
                    m_valid_next = 1'b1;
                    ev_next = mss_pkg::EV_HOLD;
                    note_next = '0;
                    oct_out_next = '0;
                    idle_out_next = 1'b1;
                end
                mss_pkg::ACT_HOLD_DEC: begin
                    hold_next = hold_reg - 1'b1;
                    m_valid_next = 1'b1;
                    ev_next = mss_pkg::EV_HOLD;
                    note_next = '0;
                    oct_out_next = '0;
                    idle_out_next = 1'b0;
                end
                mss_pkg::ACT_HOLD_ONE: begin
                    hold_next = 4'd1;
                end
                mss_pkg::ACT_EMIT_END: begin
                    idle_next = 1'b1;
                    m_valid_next = 1'b1;
                    ev_next = mss_pkg::EV_END;
                    note_next = '0;
                    oct_out_next = '0;
                    idle_out_next = 1'b1;
                end
                mss_pkg::ACT_POP: begin
                    head_next = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
                mss_pkg::ACT_APPLY: begin
                    case (rsym) inside
                        mss_pkg::SYM_ODOWN: begin
                            if (octave_reg != 4'd0) begin
                                octave_next = octave_reg - 1'b1;
                            end
                        end
                        mss_pkg::SYM_OUP: begin
                            if (octave_reg < mss_pkg::OCTAVE_MAX) begin
                                octave_next = octave_reg + 1'b1;
                            end
                        end
                        [mss_pkg::SYM_L1:mss_pkg::SYM_L16]: begin
                            hold_next = mss_pkg::hold_len(rsym);
                        end
                        default: begin
                        end
                    endcase
                end
                mss_pkg::ACT_EMIT_SYM: begin
                    m_valid_next = 1'b1;
                    idle_out_next = 1'b0;
                    if (rsym == mss_pkg::SYM_PAUSE) begin
                        ev_next = mss_pkg::EV_SILENCE;
                        note_next = '0;
                        oct_out_next = '0;
                    end else begin
                        ev_next = mss_pkg::EV_START;
                        note_next = (rsym < mss_pkg::SYM_NOTES) ? rsym[3:0] : 4'd0;
                        oct_out_next = octave_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            count_reg <= '0;
            idle_reg <= 1'b1;
            octave_reg <= mss_pkg::START_OCTAVE;
            hold_reg <= 4'd1;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg <= head_next;
            count_reg <= count_next;
            idle_reg <= idle_next;
            octave_reg <= octave_next;
            hold_reg <= hold_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (act_on && (ctrl.act == mss_pkg::ACT_ACCEPT)) begin
            kind_reg <= in_kind;
            sym_in_reg <= in_symbol;
            first_reg <= in_first;
        end
        ev_reg <= ev_next;
        note_reg <= note_next;
        oct_out_reg <= oct_out_next;
        idle_out_reg <= idle_out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign out_event = ev_reg;
    assign out_note = note_reg;
    assign out_octave = oct_out_reg;
    assign out_idle = idle_out_reg;

    assign stat.append = kind_reg;
    assign stat.idle = idle_reg;
    assign stat.hold_nz = (hold_reg != 4'd0);
    assign stat.empty = (count_reg == '0);
    assign stat.ctrl = (rsym >= mss_pkg::SYM_ODOWN) && (rsym <= mss_pkg::SYM_L16);
    assign stat.out_free = !m_valid_reg || m_tready;

endmodule

>>> rtl/melody_symbol_sequencer.sv
// Top level of the melody symbol sequencer: stream ports, control sequencer and datapath.
// Depends on mss_pkg, mss_useq, mss_dp and mss_ram.
//
//   Channel | Group | Direction | Content
//   input   | s_    | in        | tdata: symbol[4:0], first[5]; tuser: kind
//   result  | m_    | out       | tdata: event_res[1:0], note[5:2], octave_out[9:6], idle[10]
//
// An append beat steps through fetch, dispatch and append. A tick on an idle player emits after
// the idle check and one that holds after the hold check. A tick that walks the queue pops and
// applies one symbol at a time, one queue read through the registered RAM port per symbol, past
// any control symbols, until it emits a note or a pause, or the end when the queue runs empty.
// Reset is synchronous; the queue has no clearing pass and the block takes beats right after
// reset. A waiting result stalls only the step that would write the result register again.
module melody_symbol_sequencer #(
    parameter int QUEUE_DEPTH = mss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // symbol[4:0], first[5], zero fill[7:6]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // event_res[1:0], note[5:2], octave_out[9:6], idle[10], zero fill
);

    mss_pkg::ctrl_t ctrl;
    mss_pkg::stat_t stat;
    logic [1:0]     out_event;
    logic [3:0]     out_note;
    logic [3:0]     out_octave;
    logic           out_idle;

    mss_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .stat    (stat),
        .s_tready(s_tready),
        .ctrl    (ctrl)
    );

    mss_dp #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .in_kind   (s_tuser),
        .in_symbol (s_tdata[4:0]),
        .in_first  (s_tdata[5]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_event (out_event),
        .out_note  (out_note),
        .out_octave(out_octave),
        .out_idle  (out_idle),
        .stat      (stat)
    );

    assign m_tdata = {5'd0, out_idle, out_octave, out_note, out_event};

`ifndef SYNTHESIS
    a_end_is_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == mss_pkg::EV_END)) |-> m_tdata[10])
        else $error("melody-ended beat without idle set");

    a_start_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == mss_pkg::EV_START))
            |-> ((m_tdata[5:2] < 4'd12) && (m_tdata[9:6] <= mss_pkg::OCTAVE_MAX)
                && !m_tdata[10]))
        else $error("start-note beat with pitch or octave out of range");

    a_no_pitch_otherwise: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != mss_pkg::EV_START))
            |-> ((m_tdata[5:2] == 4'd0) && (m_tdata[9:6] == 4'd0)))
        else $error("pitch fields set on a beat that starts no note");

    a_one_beat_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again before the previous beat was handled");
`endif

endmodule
